[rtl/keyframe_lerp_resampler_defines.svh]
// assertion macros for the keyframe lerp resampler
`ifndef KEYFRAME_LERP_RESAMPLER_DEFINES_SVH
`define KEYFRAME_LERP_RESAMPLER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define KLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define KLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/klr_pkg.sv]
// shared types and constants for the keyframe lerp resampler
`timescale 1ns / 1ps

package klr_pkg;

    localparam int NUM_COMPS  = 4;
    localparam int COMP_W     = 32;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 7;
    localparam int INDEX_W    = 6;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 160;
    localparam int M_TDATA_W  = 168;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME     = 2'd2;

    localparam logic [TIME_W-1:0] RST_FRAME_INTERVAL = 32'd2184;
    localparam logic [CNT_W-1:0]  RST_OUTPUT_COUNT   = 7'd64;
    localparam logic [TIME_W-1:0] RST_START_TIME     = 32'd0;

    typedef struct packed {
        logic load_key;
        logic commit_key;
        logic div_start;
        logic div_step;
        logic fac_clear;
        logic mul_load;
        logic emit_lerp;
        logic emit_fill;
        logic end_track;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_due;
        logic need_div;
        logic fill_due;
        logic key_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

[rtl/klr_ctrl.sv]
// sequencing state machine for the keyframe lerp resampler
`timescale 1ns / 1ps

module klr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  klr_pkg::ctrl_stat_t stat,
    output klr_pkg::ctrl_cmd_t  cmd
);
    import klr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_TAIL  = 3'd5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_key = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.frame_due) begin
                    if (stat.need_div) begin
                        cmd.div_start = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_DIV;
                    end else begin
                        cmd.fac_clear = 1'b1;
                        state_next    = ST_MUL;
                    end
                end else begin
                    cmd.commit_key = 1'b1;
                    state_next     = ST_TAIL;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_lerp = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_TAIL: begin
                if (!stat.key_last) begin
                    state_next = ST_IDLE;
                end else if (stat.fill_due) begin
                    cmd.emit_fill = stat.out_free;
                end else begin
                    cmd.end_track = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/klr_datapath.sv]
// key storage, factor divider, lerp multipliers and output word register
`timescale 1ns / 1ps

module klr_datapath #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [klr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [klr_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    input  klr_pkg::ctrl_cmd_t                  cmd,
    output klr_pkg::ctrl_stat_t                 stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [klr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import klr_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

    // configuration
    logic [TIME_W-1:0] frame_interval_reg;
    logic [CNT_W-1:0]  output_count_reg;
    logic [TIME_W-1:0] start_time_reg;

    // track state
    logic              have_prev_reg;
    logic [CNT_W-1:0]  next_frame_reg;
    logic [TIME_W-1:0] frame_offset_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [COMP_W-1:0] prev_val_reg [NUM_COMPS];

    // current key
    logic [TIME_W-1:0] key_time_reg;
    logic [COMP_W-1:0] key_val_reg [NUM_COMPS];
    logic              key_last_reg;

    // divider and multiplier
    logic [TIME_W-1:0]    div_rem_reg;
    logic [TIME_W-1:0]    div_den_reg;
    logic [FRAC_BITS-1:0] fac_reg;
    logic [COMP_W-1:0]    prod_reg [NUM_COMPS];

    // output word
    logic              out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [COMP_W-1:0] out_val_reg [NUM_COMPS];
    logic              out_last_reg;

    logic [CNT_W-1:0]  eff_count;
    logic              out_free;
    logic [TIME_W:0]   offset_sum;
    logic [TIME_W-1:0] offset_next;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] frame_time;
    logic              frame_last;
    logic [TIME_W:0]   div_shift;
    logic              div_ge;
    logic signed [COMP_W:0]        comp_diff [NUM_COMPS];
    logic signed [COMP_W+FRAC_BITS+1:0] comp_prod [NUM_COMPS];
    logic [COMP_W-1:0] lerp_val [NUM_COMPS];
    logic              emit;

    always_comb begin
        eff_count = output_count_reg;
        if (eff_count == '0) begin
            eff_count = CNT_W'(1);
        end
        if (eff_count > MAX_CNT) begin
            eff_count = MAX_CNT;
        end
    end

    assign out_free    = !out_valid_reg || m_tready;
    assign emit        = cmd.emit_lerp || cmd.emit_fill;
    assign offset_sum  = {1'b0, frame_offset_reg} + {1'b0, frame_interval_reg};
    assign offset_next = offset_sum[TIME_W] ? '1 : offset_sum[TIME_W-1:0];
    assign time_sum    = {1'b0, start_time_reg} + {1'b0, frame_offset_reg};
    assign frame_time  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
    assign frame_last  = (next_frame_reg + 1'b1) == eff_count;
    assign div_shift   = {div_rem_reg, 1'b0};
    assign div_ge      = div_shift >= {1'b0, div_den_reg};

    always_comb begin
        for (int j = 0; j < NUM_COMPS; j++) begin
            comp_diff[j] = $signed({key_val_reg[j][COMP_W-1], key_val_reg[j]})
                         - $signed({prev_val_reg[j][COMP_W-1], prev_val_reg[j]});
            comp_prod[j] = comp_diff[j] * $signed({1'b0, fac_reg});
            lerp_val[j]  = prev_val_reg[j] + prod_reg[j];
        end
    end

    assign stat.frame_due = have_prev_reg && (next_frame_reg < eff_count)
                          && (frame_offset_reg < key_time_reg);
    assign stat.need_div  = frame_offset_reg > prev_time_reg;
    assign stat.fill_due  = next_frame_reg < eff_count;
    assign stat.key_last  = key_last_reg;
    assign stat.out_free  = out_free;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_interval_reg <= RST_FRAME_INTERVAL;
            output_count_reg   <= RST_OUTPUT_COUNT;
            start_time_reg     <= RST_START_TIME;
            have_prev_reg      <= 1'b0;
            next_frame_reg     <= '0;
            frame_offset_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_INTERVAL: frame_interval_reg <= cfg_wdata[TIME_W-1:0];
                    REG_OUTPUT_COUNT:   output_count_reg   <= cfg_wdata[CNT_W-1:0];
                    REG_START_TIME:     start_time_reg     <= cfg_wdata[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.commit_key) begin
                have_prev_reg <= 1'b1;
            end
            if (emit) begin
                next_frame_reg   <= next_frame_reg + 1'b1;
                frame_offset_reg <= offset_next;
            end
            if (cmd.end_track) begin
                have_prev_reg    <= 1'b0;
                next_frame_reg   <= '0;
                frame_offset_reg <= '0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_time_reg <= s_tdata[TIME_W-1:0];
            for (int j = 0; j < NUM_COMPS; j++) begin
                key_val_reg[j] <= s_tdata[TIME_W + j*COMP_W +: COMP_W];
            end
            key_last_reg <= s_tlast;
        end
        if (cmd.commit_key) begin
            prev_time_reg <= key_time_reg;
            for (int j = 0; j < NUM_COMPS; j++) begin
                prev_val_reg[j] <= key_val_reg[j];
            end
        end
        if (cmd.div_start) begin
            div_rem_reg <= frame_offset_reg - prev_time_reg;
            div_den_reg <= key_time_reg - prev_time_reg;
            fac_reg     <= '0;
        end else if (cmd.div_step) begin
            if (div_ge) begin
                div_rem_reg <= TIME_W'(div_shift - {1'b0, div_den_reg});
            end else begin
                div_rem_reg <= div_shift[TIME_W-1:0];
            end
            fac_reg <= {fac_reg[FRAC_BITS-2:0], div_ge};
        end else if (cmd.fac_clear) begin
            fac_reg <= '0;
        end
        if (cmd.mul_load) begin
            for (int j = 0; j < NUM_COMPS; j++) begin
                prod_reg[j] <= comp_prod[j][COMP_W+FRAC_BITS-1:FRAC_BITS];
            end
        end
        if (emit) begin
            out_index_reg <= next_frame_reg[INDEX_W-1:0];
            out_time_reg  <= frame_time;
            out_last_reg  <= frame_last;
            for (int j = 0; j < NUM_COMPS; j++) begin
                out_val_reg[j] <= cmd.emit_fill ? key_val_reg[j] : lerp_val[j];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_val_reg[3], out_val_reg[2], out_val_reg[1],
                       out_val_reg[0], out_time_reg, out_index_reg};

endmodule

[rtl/keyframe_lerp_resampler.sv]
// Keyframe lerp resampler. Keys (time, four components) come in on the s_ word
// channel in time order and resampled frames leave on the m_ channel. One key
// is worked on at a time: a key is accepted, then checked, and once no further
// frame is due it is committed and passes to the tail state. Each frame that
// falls strictly inside the segment takes one check, 16 steps of the shared
// restoring divider that forms the Q0.16 factor, one multiply and one load of
// the output register; a frame at or before the previous key has its factor
// cleared in place of the divider steps. Fill frames after the last key are
// loaded from the tail state, and the track is closed after the fill. A frame
// waits in its load state while the output register holds an unaccepted word.
// Once the last frame of a key is loaded, the controller returns to idle
// without waiting for that word, so it does not hold off the next key.
`timescale 1ns / 1ps

module keyframe_lerp_resampler #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [klr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_time, comp_x, comp_y, comp_z, comp_w
    input  logic [klr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_index, frame_time, out_x, out_y, out_z, out_w, zero fill
    output logic [klr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import klr_pkg::*;

`include "keyframe_lerp_resampler_defines.svh"

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       emit_any;
    logic       cmd_onehot;

    klr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    klr_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    assign emit_any   = cmd.emit_lerp || cmd.emit_fill;
    assign cmd_onehot = $onehot0({cmd.load_key, cmd.div_start, cmd.mul_load, cmd.emit_lerp,
                                  cmd.emit_fill, cmd.end_track});

    `KLR_ASSERT_SAME(a_emit_needs_slot, emit_any, stat.out_free, "frame loaded over a waiting word")
    `KLR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "key taken while busy")
    `KLR_ASSERT_SAME(a_single_cmd, 1'b1, cmd_onehot, "conflicting commands")
    `KLR_ASSERT_NEXT(a_emit_shows, emit_any, m_tvalid, "loaded frame not presented")

endmodule

[bench/klr_checker.sv]
// frame predictor and checker for the keyframe lerp resampler
`timescale 1ns / 1ps

module klr_checker #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [klr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [klr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [klr_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               pending
);
    import klr_pkg::*;

    typedef logic [NUM_COMPS-1:0][COMP_W-1:0] comps_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [TIME_W-1:0]  ftime;
        comps_t             comp;
        logic               last;
    } frame_t;

    logic [TIME_W-1:0] interval_r;
    logic [CNT_W-1:0]  count_r;
    logic [TIME_W-1:0] start_r;

    logic [TIME_W-1:0] prev_time;
    comps_t            prev_val;
    bit                have_prev;
    int unsigned       next_idx;
    logic [TIME_W-1:0] offset;

    frame_t frame_q[$];

    function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // a + floor((b - a) * f / 2^16)
    function automatic logic [COMP_W-1:0] lerp(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
                                               logic [FRAC_BITS:0] f);
        longint d;
        longint p;
        d = longint'(signed'(b)) - longint'(signed'(a));
        p = d * longint'(f);
        return COMP_W'(longint'(signed'(a)) + (p >>> FRAC_BITS));
    endfunction

    function automatic void push_frame(comps_t vals, int unsigned cnt);
        frame_t e;
        e.index = next_idx[INDEX_W-1:0];
        e.ftime = sat_sum(start_r, offset);
        e.comp  = vals;
        e.last  = (next_idx + 1 == cnt);
        frame_q.push_back(e);
        next_idx++;
        offset = sat_sum(offset, interval_r);
    endfunction

    function automatic void take_key(logic [TIME_W-1:0] kt, comps_t kv, logic last);
        int unsigned       cnt;
        logic [47:0]       num;
        logic [47:0]       quo;
        logic [TIME_W-1:0] den;
        logic [FRAC_BITS:0] f;
        comps_t            v;
        cnt = (count_r == 0) ? 1 : ((count_r > MAX_FRAMES) ? MAX_FRAMES : count_r);
        if (have_prev) begin
            while (next_idx < cnt && offset < kt) begin
                f = '0;
                if (offset > prev_time) begin
                    num = {offset - prev_time, 16'h0000};
                    den = kt - prev_time;
                    quo = num / {16'h0000, den};
                    f = (quo > 48'd65536) ? 17'd65536 : quo[FRAC_BITS:0];
                end
                for (int j = 0; j < NUM_COMPS; j++) begin
                    v[j] = lerp(prev_val[j], kv[j], f);
                end
                push_frame(v, cnt);
            end
        end
        prev_time = kt;
        prev_val  = kv;
        have_prev = 1'b1;
        if (last) begin
            while (next_idx < cnt) begin
                push_frame(kv, cnt);
            end
            have_prev = 1'b0;
            next_idx  = 0;
            offset    = '0;
        end
    endfunction

    function automatic void check_field(logic [INDEX_W-1:0] idx, string name,
                                        logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: frame %0d %s expected %h actual %h", $time, idx, name, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        frame_t want;
        if (!aresetn) begin
            interval_r = RST_FRAME_INTERVAL;
            count_r    = RST_OUTPUT_COUNT;
            start_r    = RST_START_TIME;
            prev_time  = '0;
            prev_val   = '0;
            have_prev  = 1'b0;
            next_idx   = 0;
            offset     = '0;
            frame_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = frame_q.pop_front();
                    check_field(want.index, "frame_index", 32'(want.index),
                                32'(m_tdata[INDEX_W-1:0]));
                    check_field(want.index, "frame_time", want.ftime,
                                m_tdata[INDEX_W +: TIME_W]);
                    check_field(want.index, "out_x", want.comp[0],
                                m_tdata[INDEX_W + TIME_W +: COMP_W]);
                    check_field(want.index, "out_y", want.comp[1],
                                m_tdata[INDEX_W + TIME_W + COMP_W +: COMP_W]);
                    check_field(want.index, "out_z", want.comp[2],
                                m_tdata[INDEX_W + TIME_W + 2*COMP_W +: COMP_W]);
                    check_field(want.index, "out_w", want.comp[3],
                                m_tdata[INDEX_W + TIME_W + 3*COMP_W +: COMP_W]);
                    check_field(want.index, "last_frame", 32'(want.last), 32'(m_tlast));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_INTERVAL: interval_r = cfg_wdata[TIME_W-1:0];
                    REG_OUTPUT_COUNT:   count_r    = cfg_wdata[CNT_W-1:0];
                    REG_START_TIME:     start_r    = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_key(s_tdata[TIME_W-1:0], s_tdata[TIME_W +: NUM_COMPS*COMP_W], s_tlast);
            end
        end
        pending = frame_q.size();
    end

endmodule

[bench/tb_keyframe_lerp_resampler.sv]
// top-level testbench for the keyframe lerp resampler: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb_keyframe_lerp_resampler;
    import klr_pkg::*;

    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_KEYS    = 50;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;

    int mismatches;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;

    logic [31:0] cur_interval = 32'd2184;
    int unsigned cur_count    = 64;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    keyframe_lerp_resampler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    klr_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_key(logic [31:0] kt, logic [3:0][31:0] kv, logic last);
        while ($urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {kv, kt};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off keys until every frame is out and the block has settled
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] interval, logic [6:0] count, logic [31:0] start);
        write_reg(REG_FRAME_INTERVAL, interval);
        write_reg(REG_OUTPUT_COUNT, 32'(count));
        write_reg(REG_START_TIME, start);
        cur_interval = interval;
        cur_count    = (count == 0) ? 1 : ((count > 64) ? 64 : count);
    endtask

    task automatic random_setting();
        logic [31:0] interval;
        logic [6:0]  count;
        logic [31:0] start;
        case ($urandom_range(9))
            0: interval = 32'd1;
            1: interval = 32'hFFFF_FFFF;
            2: interval = $urandom;
            default: interval = $urandom_range(1, 5000);
        endcase
        case ($urandom_range(9))
            0: count = 7'd0;
            1: count = 7'd64;
            2: count = 7'($urandom_range(65, 127));
            default: count = 7'($urandom_range(1, 16));
        endcase
        case ($urandom_range(9))
            0: start = 32'd0;
            1: start = 32'hFFFF_FFFF;
            default: start = $urandom;
        endcase
        set_regs(interval, count, start);
    endtask

    function automatic logic [3:0][31:0] random_comps();
        logic [3:0][31:0] v;
        for (int j = 0; j < 4; j++) begin
            case ($urandom_range(7))
                0: v[j] = MAXV;
                1: v[j] = MINV;
                default: v[j] = $urandom;
            endcase
        end
        return v;
    endfunction

    // time-ordered keys spread over the frame span, with some equal, early or wild times
    task automatic random_track(int keys);
        longint      span;
        longint      step_max;
        longint      nxt;
        logic [31:0] t;
        span = longint'(cur_count) * longint'(cur_interval);
        step_max = span * 2 / keys + 1;
        if (step_max > 64'hFFFF_FFFF) step_max = 64'hFFFF_FFFF;
        t = $urandom_range(0, 32'(step_max / 2));
        for (int k = 0; k < keys; k++) begin
            case ($urandom_range(19))
                0: t = $urandom;
                1: ;
                default: begin
                    nxt = longint'(t) + longint'($urandom_range(0, 32'(step_max)));
                    t = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(nxt);
                end
            endcase
            send_key(t, random_comps(), k == keys - 1);
        end
    endtask

    task automatic random_phase(int snd, int rcv);
        int sent;
        int keys;
        send_idle = snd;
        recv_idle = rcv;
        sent = 0;
        drain();
        random_setting();
        while (sent < PHASE_KEYS) begin
            if ($urandom_range(3) == 0) begin
                drain();
                random_setting();
            end
            keys = $urandom_range(1, 6);
            random_track(keys);
            sent += keys;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single key that is also last, reset settings
        send_key(32'h0000_1000, {MAXV, MINV, MAXV, MINV}, 1'b1);

        // early key, out-of-order key, key on a frame time, repeated time, far last key
        send_key(32'd50000, {MINV, MINV, MINV, MINV}, 1'b0);
        send_key(32'd3000,  {MAXV, MAXV, MAXV, MAXV}, 1'b0);
        send_key(32'd21840, {MINV, MAXV, MINV, MAXV}, 1'b0);
        send_key(32'd21840, {MAXV, MINV, MAXV, MINV}, 1'b0);
        send_key(32'd40000, random_comps(), 1'b0);
        send_key(32'hFFFF_FFFF, {32'd0, 32'd0, 32'd0, 32'd0}, 1'b1);

        // count lowered below the frames already sent
        drain();
        send_key(32'd0, random_comps(), 1'b0);
        send_key(32'd10000, random_comps(), 1'b0);
        drain();
        set_regs(32'd2184, 7'd3, 32'd0);
        send_key(32'd30000, random_comps(), 1'b0);
        send_key(32'd40000, random_comps(), 1'b1);

        // count zero acts as one
        drain();
        set_regs(32'd2184, 7'd0, 32'd0);
        send_key(32'd100, random_comps(), 1'b0);
        send_key(32'd200, random_comps(), 1'b1);

        // saturated offsets and frame times, count above the maximum
        drain();
        set_regs(32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF);
        send_key(32'd5, random_comps(), 1'b0);
        send_key(32'hFFFF_FFFF, random_comps(), 1'b0);
        send_key(32'hFFFF_FFFF, random_comps(), 1'b1);

        drain();
        set_regs(32'd1, 7'd1, 32'd0);
        send_key(32'd0, random_comps(), 1'b1);

        // dense grid inside one wide segment
        drain();
        set_regs(32'd1, 7'd64, 32'h1234_5678);
        send_key(32'd0, {MINV, MINV, MINV, MINV}, 1'b0);
        send_key(32'd100, {MAXV, MAXV, MAXV, MAXV}, 1'b1);

        random_phase(7, 83);
        random_phase(83, 7);
        random_phase(0, 0);

        drain();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
